// ===== hw/rtl/pcn_pkg.sv =====
// Package for the perpetual calendar navigator: field widths, mode codes,
// month tables and the status word passed from the year walker.
// No dependencies.
`timescale 1ns / 1ps

package pcn_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int MLEN_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int MODE_W  = 3;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_LOAD       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT_YEAR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PREV_YEAR  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NEXT_MONTH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PREV_MONTH = 3'd4;

	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

	// Status of the year walker
	typedef struct packed {
		logic                at_target;
		logic                leap;
		logic [WDAY_W-1:0]   jan1_wday;
	} pcn_walk_t;

	// Days in a month of a common year
	function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m);
		logic [MLEN_W-1:0] d;
		case (m)
			4'd2:                 d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:              d = 5'd31;
		endcase
		return d;
	endfunction

	// Days before the month in a common year, reduced modulo 7
	function automatic logic [WDAY_W-1:0] month_offset7(input logic [MONTH_W-1:0] m);
		logic [WDAY_W-1:0] o;
		case (m)
			4'd2:    o = 3'd3;
			4'd3:    o = 3'd3;
			4'd4:    o = 3'd6;
			4'd5:    o = 3'd1;
			4'd6:    o = 3'd4;
			4'd7:    o = 3'd6;
			4'd8:    o = 3'd2;
			4'd9:    o = 3'd5;
			4'd10:   o = 3'd0;
			4'd11:   o = 3'd3;
			4'd12:   o = 3'd5;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

endpackage

// ===== hw/rtl/pcn_year_walk.sv =====
// Year walker: one shared step unit that moves a year position by one per
// cycle while enabled toward a target, keeping the weekday of 1 January and leap residues.
// Depends on pcn_pkg.
`timescale 1ns / 1ps

module pcn_year_walk #(
	parameter int EPOCH_YEAR = 1900
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [pcn_pkg::YEAR_W-1:0] target,
	output pcn_pkg::pcn_walk_t         status
);
	import pcn_pkg::*;

	localparam logic [YEAR_W-1:0] EPOCH = YEAR_W'(EPOCH_YEAR);
	localparam logic [1:0]        R4_0   = 2'(EPOCH_YEAR % 4);
	localparam logic [6:0]        R100_0 = 7'(EPOCH_YEAR % 100);
	localparam logic [8:0]        R400_0 = 9'(EPOCH_YEAR % 400);

	logic [YEAR_W-1:0] year_q;
	logic [WDAY_W-1:0] wday_q;
	logic [1:0]        r4_q;
	logic [6:0]        r100_q;
	logic [8:0]        r400_q;

	logic              at;
	logic              fwd;
	logic              leap_cur;
	logic              leap_dn;
	logic [1:0]        r4_dn;
	logic [6:0]        r100_dn;
	logic [8:0]        r400_dn;
	logic [1:0]        r4_up;
	logic [6:0]        r100_up;
	logic [8:0]        r400_up;
	logic [3:0]        wsum;
	logic [WDAY_W-1:0] wday_nxt;

	// Compare and residue arithmetic
	always_comb begin
		at       = (year_q == target);
		fwd      = (target > year_q);
		leap_cur = (r400_q == 9'd0) || ((r4_q == 2'd0) && (r100_q != 7'd0));

		r4_up   = r4_q + 2'd1;
		r100_up = (r100_q == 7'd99)  ? 7'd0 : r100_q + 7'd1;
		r400_up = (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
		r4_dn   = r4_q - 2'd1;
		r100_dn = (r100_q == 7'd0) ? 7'd99  : r100_q - 7'd1;
		r400_dn = (r400_q == 9'd0) ? 9'd399 : r400_q - 9'd1;
		leap_dn = (r400_dn == 9'd0) || ((r4_dn == 2'd0) && (r100_dn != 7'd0));

		// A year shifts the weekday by 1, or 2 when it is a leap year
		if (fwd) begin
			wsum = {1'b0, wday_q} + (leap_cur ? 4'd2 : 4'd1);
		end else begin
			wsum = {1'b0, wday_q} + 4'd7 - (leap_dn ? 4'd2 : 4'd1);
		end
		wday_nxt = (wsum >= 4'd7) ? WDAY_W'(wsum - 4'd7) : WDAY_W'(wsum);
	end

	// Advance one year per cycle toward the target while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= EPOCH;
			wday_q <= '0;
			r4_q   <= R4_0;
			r100_q <= R100_0;
			r400_q <= R400_0;
		end else if (en && !at) begin
			wday_q <= wday_nxt;
			if (fwd) begin
				year_q <= year_q + 1'b1;
				r4_q   <= r4_up;
				r100_q <= r100_up;
				r400_q <= r400_up;
			end else begin
				year_q <= year_q - 1'b1;
				r4_q   <= r4_dn;
				r100_q <= r100_dn;
				r400_q <= r400_dn;
			end
		end
	end

	assign status.at_target = at;
	assign status.leap      = leap_cur;
	assign status.jan1_wday = wday_q;

endmodule

// ===== hw/rtl/perpetual_calendar_navigator_unit.sv =====
// Perpetual calendar navigator top level: item decode, month/year state,
// sequencer around the year walker and the output word register.
// Depends on pcn_pkg and pcn_year_walk.
`timescale 1ns / 1ps

// An accepted item drives the year walker from Y_old, the year of the
// previous item's result (the reset year before the first item), to Y_new,
// the year after this item, and then its word is registered. The walker
// moves its position by one year per cycle while the sequencer is walking
// and keeps it between items, so month and single year steps take at most
// one year step and a load walks the distance between the two years. The
// input side accepts one item at a time; a finished word may wait in the
// output register while the next item is taken.
module perpetual_calendar_navigator_unit #(
	parameter int MAX_YEAR   = 9999,
	parameter int EPOCH_YEAR = 1900
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[2:0], load_month[6:3], load_year[20:7], zero fill [23:21]
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// month_now[3:0], year_now[17:4], month_length[22:18],
	// first_weekday[25:23], bad_month[26], zero fill [31:27]
	output logic [31:0] m_tdata
);
	import pcn_pkg::*;

	localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic               bad_q;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	logic [MODE_W-1:0]  in_mode;
	logic [MONTH_W-1:0] in_month;
	logic [YEAR_W-1:0]  in_year;
	logic               accept;
	logic [MONTH_W-1:0] month_nxt;
	logic [YEAR_W-1:0]  year_nxt;
	logic               bad_nxt;
	logic               out_free;
	pcn_walk_t          walk;
	logic [MLEN_W-1:0]  mlen;
	logic [3:0]         wsum;
	logic [WDAY_W-1:0]  wday;

	assign in_mode  = s_tdata[2:0];
	assign in_month = s_tdata[6:3];
	assign in_year  = s_tdata[20:7];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Decode the item into the next month and year
	always_comb begin
		month_nxt = month_q;
		year_nxt  = year_q;
		bad_nxt   = 1'b0;
		case (in_mode)
			MODE_LOAD: begin
				if (in_month >= JANUARY && in_month <= DECEMBER) begin
					month_nxt = in_month;
					year_nxt  = (in_year > YMAX) ? YMAX : in_year;
				end else begin
					bad_nxt = 1'b1;
				end
			end
			MODE_NEXT_YEAR: begin
				if (year_q < YMAX) year_nxt = year_q + 1'b1;
			end
			MODE_PREV_YEAR: begin
				if (year_q != '0) year_nxt = year_q - 1'b1;
			end
			MODE_NEXT_MONTH: begin
				if (month_q < DECEMBER) begin
					month_nxt = month_q + 1'b1;
				end else if (year_q < YMAX) begin
					month_nxt = JANUARY;
					year_nxt  = year_q + 1'b1;
				end
			end
			MODE_PREV_MONTH: begin
				if (month_q > JANUARY) begin
					month_nxt = month_q - 1'b1;
				end else if (year_q != '0) begin
					month_nxt = DECEMBER;
					year_nxt  = year_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	pcn_year_walk #(
		.EPOCH_YEAR(EPOCH_YEAR)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (state_q == ST_WALK),
		.target(year_q),
		.status(walk)
	);

	// Month length and weekday of the first day from the walker's result
	always_comb begin
		mlen = month_days(month_q) +
			MLEN_W'((month_q == FEBRUARY && walk.leap) ? 1 : 0);
		wsum = {1'b0, walk.jan1_wday} + {1'b0, month_offset7(month_q)} +
			4'((month_q > FEBRUARY && walk.leap) ? 1 : 0);
		wday = (wsum >= 4'd7) ? WDAY_W'(wsum - 4'd7) : WDAY_W'(wsum);
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			month_q <= JANUARY;
			year_q  <= YEAR_W'(1900);
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						month_q <= month_nxt;
						year_q  <= year_nxt;
						bad_q   <= bad_nxt;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk.at_target) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the output word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {5'd0, bad_q, wday, mlen, year_q, month_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/pcn_checker.sv =====
// Port-level checker for the perpetual calendar navigator, bound to the
// top level. Depends only on the top level's ports.
`timescale 1ns / 1ps

module pcn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word dropped or changed");

	// Drop ready right after an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// Keep month, length and weekday in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] >= 4'd1 && m_tdata[3:0] <= 4'd12 &&
			m_tdata[22:18] >= 5'd28 && m_tdata[22:18] <= 5'd31 &&
			m_tdata[25:23] <= 3'd6)
		else $error("output field out of range");

	// Keep short months consistent with February
	a_feb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22:18] <= 5'd29 |-> m_tdata[3:0] == 4'd2)
		else $error("short month length outside February");

endmodule

bind perpetual_calendar_navigator_unit pcn_checker u_pcn_checker (.*);

// ===== tb/sv/calendar_word_checker.sv =====
// Watches both stream channels of the perpetual calendar navigator, keeps
// its own copy of the month/year state and checks every result word.
// Depends on pcn_pkg for field widths and mode codes.
`timescale 1ns / 1ps

module calendar_word_checker #(
	parameter int MAX_YEAR   = 9999,
	parameter int EPOCH_YEAR = 1900
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// mode[2:0], load_month[6:3], load_year[20:7], zero fill [23:21]
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// month_now[3:0], year_now[17:4], month_length[22:18],
	// first_weekday[25:23], bad_month[26], zero fill [31:27]
	input  logic [31:0] m_tdata,
	output int          fail_count,
	output int          pending_words,
	output int          words_checked
);
	import pcn_pkg::*;

	// Result word laid out as on m_tdata, first field in the top bits
	typedef struct packed {
		logic                 bad;
		logic [WDAY_W-1:0]    wday;
		logic [MLEN_W-1:0]    mlen;
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
	} cal_word_t;

	int common_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	int cal_month = 1;
	int cal_year  = 1900;
	cal_word_t due_words [$];

	function automatic bit leap_year(input int y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	// Days from 1 January of year 0 to 1 January of year y
	function automatic longint days_since_zero(input int y);
		longint d;
		d = longint'(y) * 365;
		if (y > 0)
			d += 1 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
		return d;
	endfunction

	// Apply one word to the calendar state and build the expected result
	function automatic cal_word_t step_calendar(input logic [MODE_W-1:0] mode,
			input int lmon, input int lyr);
		cal_word_t w;
		int mi;
		bit leap;
		longint off;
		w.bad = 1'b0;
		case (mode)
			MODE_LOAD: begin
				if (lmon >= 1 && lmon <= 12) begin
					cal_month = lmon;
					cal_year  = (lyr > MAX_YEAR) ? MAX_YEAR : lyr;
				end else begin
					w.bad = 1'b1;
				end
			end
			MODE_NEXT_YEAR: begin
				if (cal_year < MAX_YEAR)
					cal_year++;
			end
			MODE_PREV_YEAR: begin
				if (cal_year > 0)
					cal_year--;
			end
			MODE_NEXT_MONTH: begin
				if (cal_month < DECEMBER) begin
					cal_month++;
				end else if (cal_year < MAX_YEAR) begin
					cal_month = JANUARY;
					cal_year++;
				end
			end
			MODE_PREV_MONTH: begin
				if (cal_month > JANUARY) begin
					cal_month--;
				end else if (cal_year > 0) begin
					cal_month = DECEMBER;
					cal_year--;
				end
			end
			default: begin
			end
		endcase

		// Month length and weekday of the 1st, counted from the epoch Monday
		mi   = cal_month - 1;
		leap = leap_year(cal_year);
		off  = days_since_zero(cal_year) - days_since_zero(EPOCH_YEAR);
		for (int k = 0; k < mi; k++)
			off += common_len[k];
		if (mi >= 2 && leap)
			off++;
		off %= 7;
		if (off < 0)
			off += 7;

		w.month = MONTH_W'(cal_month);
		w.year  = YEAR_W'(cal_year);
		w.mlen  = MLEN_W'(common_len[mi] + ((mi == 1 && leap) ? 1 : 0));
		w.wday  = WDAY_W'(off);
		return w;
	endfunction

	// Retire result words first, then queue the prediction for a new word
	always @(posedge clk or negedge arst_n) begin
		cal_word_t got;
		cal_word_t want;
		if (!arst_n) begin
			cal_month = JANUARY;
			cal_year  = 1900;
			due_words.delete();
			fail_count    = 0;
			words_checked = 0;
			pending_words <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[26:0];
				if (due_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word %h with no item outstanding",
							$realtime, m_tdata);
				end else begin
					want = due_words.pop_front();
					words_checked++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: mismatch exp month %0d year %0d len %0d",
								" wday %0d bad %0d",
								" / got month %0d year %0d len %0d wday %0d bad %0d"},
								$realtime, want.month, want.year, want.mlen, want.wday,
								want.bad, got.month, got.year, got.mlen, got.wday,
								got.bad);
					end
				end
			end
			if (s_tvalid && s_tready)
				due_words.push_back(step_calendar(s_tdata[2:0], int'(s_tdata[6:3]),
					int'(s_tdata[20:7])));
			pending_words <= due_words.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Regression top for the perpetual calendar navigator: clock, reset,
// stimulus on the input stream, output back-pressure and the verdict.
// Depends on pcn_pkg, perpetual_calendar_navigator_unit and calendar_word_checker.
`timescale 1ns / 1ps

module tb;
	import pcn_pkg::*;

	localparam int MAX_YEAR   = 9999;
	localparam int EPOCH_YEAR = 1900;

	// Modes 5..7 do nothing but report the current month
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS   = 100;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES    = 64;
	// The directed walk and the random part, even with every random item a
	// full-range load that walks across the year range from 0 to MAX_YEAR,
	// plus the random input and output gaps per word, stay well under this limit.
	localparam int CYCLE_LIMIT    = 5_000_000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int fail_count;
	int pending_words;
	int words_checked;

	bit calm    = 1'b0;
	bit hold_rx = 1'b0;
	int n_load  = 0;
	int n_year  = 0;
	int n_month = 0;
	int n_spare = 0;
	int cycles  = 0;

	perpetual_calendar_navigator_unit #(
		.MAX_YEAR  (MAX_YEAR),
		.EPOCH_YEAR(EPOCH_YEAR)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	calendar_word_checker #(
		.MAX_YEAR  (MAX_YEAR),
		.EPOCH_YEAR(EPOCH_YEAR)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending_words(pending_words),
		.words_checked(words_checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("perpetual_calendar_navigator_unit regression: fail");
		$finish;
	end

	// Offer one word after a random gap and hold it until taken
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [MONTH_W-1:0] month,
			input logic [YEAR_W-1:0] year);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {3'b000, year, month, mode};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (mode)
			MODE_LOAD:                       n_load++;
			MODE_NEXT_YEAR, MODE_PREV_YEAR:  n_year++;
			MODE_NEXT_MONTH, MODE_PREV_MONTH: n_month++;
			default:                         n_spare++;
		endcase
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
	endtask

	// Output side: random ready gaps, one long hold when asked
	initial begin
		int gap;
		bit held;
		wait (arst_n);
		forever begin
			if (hold_rx && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = calm ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		int pick;
		int anchor;
		int yr;
		logic [MODE_W-1:0]  md;
		logic [MONTH_W-1:0] mo;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Spare modes straight out of reset report January 1900
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
			send_item(MODE_W'(m), 4'd0, '0);
		// Leap rule: divisible by 400, century, by 4; then a year before the epoch
		send_item(MODE_LOAD, FEBRUARY, 14'd2000);
		send_item(MODE_LOAD, FEBRUARY, 14'd1900);
		send_item(MODE_LOAD, FEBRUARY, 14'd2024);
		send_item(MODE_LOAD, DECEMBER, 14'd1899);
		// Bad load months keep the state
		send_item(MODE_LOAD, 4'd0, 14'd5000);
		send_item(MODE_LOAD, 4'd15, 14'h2aaa);
		send_item(MODE_LOAD, 4'd13, 14'd1234);
		// Year zero: leap, and both backward steps are pinned
		send_item(MODE_LOAD, JANUARY, 14'd0);
		send_item(MODE_PREV_MONTH, 4'd0, '0);
		send_item(MODE_PREV_YEAR, 4'd0, '0);
		send_item(MODE_NEXT_MONTH, 4'd0, '0);
		// Top year: load saturates, forward steps are pinned
		send_item(MODE_LOAD, DECEMBER, 14'h3fff);
		send_item(MODE_NEXT_MONTH, 4'd0, '0);
		send_item(MODE_NEXT_YEAR, 4'd0, '0);
		send_item(MODE_PREV_YEAR, 4'd0, '0);
		// Month steps carrying across the year
		send_item(MODE_LOAD, DECEMBER, 14'd1999);
		send_item(MODE_NEXT_MONTH, 4'd0, '0);
		send_item(MODE_PREV_MONTH, 4'd0, '0);
		send_item(MODE_LOAD, 4'd8, 14'h1555);
		anchor = 14'h1555;

		// Random part: mostly steps and nearby loads, a few full-range loads and spare modes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 60 && i < 80);
			if (i == 30)
				hold_rx = 1'b1;
			if (i == 50)
				wait_for_results();
			pick = $urandom_range(0, 99);
			mo   = MONTH_W'($urandom_range(0, 15));
			yr   = 0;
			if (pick < 30) begin
				md = MODE_LOAD;
				if ($urandom_range(0, 5) == 0) begin
					yr = $urandom_range(0, 16383);
				end else begin
					yr = anchor - 40 + $urandom_range(0, 80);
					if (yr < 0)
						yr = 0;
				end
				if (mo >= JANUARY && mo <= DECEMBER)
					anchor = (yr > MAX_YEAR) ? MAX_YEAR : yr;
			end else if (pick < 90) begin
				md = MODE_W'($urandom_range(MODE_NEXT_YEAR, MODE_PREV_MONTH));
			end else begin
				md = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			end
			send_item(md, mo, YEAR_W'(yr));
		end
		calm = 1'b0;

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d loads, %0d year steps, %0d month steps, %0d spare-mode words",
			n_load, n_year, n_month, n_spare);
		$display("checked %0d result words, with a %0d-cycle output stall and a mid-run drain",
			words_checked, RX_HOLD_CYCLES);
		if (fail_count == 0)
			$display("perpetual_calendar_navigator_unit regression: pass");
		else
			$display("perpetual_calendar_navigator_unit regression: fail");
		$finish;
	end

endmodule
